### hdl/cpenc_pkg.sv
package cpenc_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrBits = $clog2(QueueDepth);
   localparam int unsigned QueueCountBits = $clog2(QueueDepth + 1);

   localparam logic [10:0] CyrOffset = 11'h350;
   localparam logic [7:0] CyrFirst = 8'hC0;
   localparam logic [7:0] HighFirst = 8'h80;
   localparam logic [7:0] YoUpper = 8'hA8;
   localparam logic [7:0] YoLower = 8'hB8;
   localparam logic [7:0] YoUpperHi = 8'hD0;
   localparam logic [7:0] YoUpperLo = 8'h81;
   localparam logic [7:0] YoLowerHi = 8'hD1;
   localparam logic [7:0] YoLowerLo = 8'h91;
   localparam logic [7:0] Utf8LeadMark = 8'hC0;
   localparam logic [7:0] Utf8ContMark = 8'h80;
   localparam logic [7:0] PercentChar = 8'h25;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_RAW,
      KIND_ESC1,
      KIND_ESC2
   } kind_type;

   typedef enum logic [2:0] {
      STEP_FIRST_PCT,
      STEP_FIRST_HI,
      STEP_FIRST_LO,
      STEP_SECOND_PCT,
      STEP_SECOND_HI,
      STEP_SECOND_LO
   } step_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte0;
      logic [7:0] byte1;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
      logic [7:0] digit;
      if (nibble < 4'd10) begin
         digit = 8'h30 + {4'd0, nibble};
      end else begin
         digit = 8'h57 + {4'd0, nibble};
      end
      return digit;
   endfunction

   function automatic logic is_reserved(input logic [7:0] b);
      logic hit;
      case (b)
         8'h0A, 8'h20, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2B, 8'h2C,
         8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h7E: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

### hdl/cpenc_front.sv
module cpenc_front
   import cpenc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       accept,
   input  logic [7:0] char_byte,
   output logic       push,
   output entry_type  entry
);

   logic        escape_reserved_ff;
   logic        escape_reserved_in;
   logic [10:0] code_point;

   always_comb begin
      escape_reserved_in = escape_reserved_ff;
      if (csr_wr_en) begin
         escape_reserved_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_reserved_ff <= 1'b1;
      end else begin
         escape_reserved_ff <= escape_reserved_in;
      end
   end

   assign code_point = CyrOffset + {3'd0, char_byte};

   always_comb begin
      entry.kind  = KIND_RAW;
      entry.byte0 = char_byte;
      entry.byte1 = char_byte;
      if (char_byte >= CyrFirst) begin
         entry.kind  = KIND_ESC2;
         entry.byte0 = Utf8LeadMark | {3'd0, code_point[10:6]};
         entry.byte1 = Utf8ContMark | {2'd0, code_point[5:0]};
      end else if (char_byte == YoUpper) begin
         entry.kind  = KIND_ESC2;
         entry.byte0 = YoUpperHi;
         entry.byte1 = YoUpperLo;
      end else if (char_byte == YoLower) begin
         entry.kind  = KIND_ESC2;
         entry.byte0 = YoLowerHi;
         entry.byte1 = YoLowerLo;
      end else if (char_byte >= HighFirst) begin
         entry.kind = KIND_NONE;
      end else if (escape_reserved_ff && is_reserved(char_byte)) begin
         entry.kind = KIND_ESC1;
      end
   end

   assign push = accept && (entry.kind != KIND_NONE);

endmodule

### hdl/cpenc_queue.sv
module cpenc_queue
   import cpenc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type status
);

   entry_type                   slots_ff [QueueDepth];
   logic [QueuePtrBits-1:0]     wr_ptr_ff;
   logic [QueuePtrBits-1:0]     wr_ptr_in;
   logic [QueuePtrBits-1:0]     rd_ptr_ff;
   logic [QueuePtrBits-1:0]     rd_ptr_in;
   logic [QueueCountBits-1:0]   count_ff;
   logic [QueueCountBits-1:0]   count_in;

   assign status.full  = (count_ff == QueueCountBits'(QueueDepth));
   assign status.empty = (count_ff == '0);
   assign head         = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCountBits'(QueueDepth))
      else $error("queue count exceeds depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("pop from empty queue");
`endif

endmodule

### hdl/cpenc_back.sv
module cpenc_back
   import cpenc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  entry_type        head,
   input  queue_status_type status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_last_of_run
);

   step_type   step_ff;
   step_type   step_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] rsp_char_ff;
   logic [7:0] rsp_char_in;
   logic       rsp_last_ff;
   logic       rsp_last_in;
   logic       load;
   logic       fire;
   logic       is_last;

   assign load = !rsp_valid_ff || !rsp_stall;
   assign fire = load && !status.empty;

   always_comb begin
      is_last = 1'b0;
      if (head.kind == KIND_RAW) begin
         is_last = 1'b1;
      end else if (head.kind == KIND_ESC1 && step_ff == STEP_FIRST_LO) begin
         is_last = 1'b1;
      end else if (step_ff == STEP_SECOND_LO) begin
         is_last = 1'b1;
      end
   end

   assign pop = fire && is_last;

   always_comb begin
      case (step_ff)
         STEP_FIRST_PCT: begin
            rsp_char_in = (head.kind == KIND_RAW) ? head.byte0 : PercentChar;
         end
         STEP_FIRST_HI:   rsp_char_in = hex_digit(head.byte0[7:4]);
         STEP_FIRST_LO:   rsp_char_in = hex_digit(head.byte0[3:0]);
         STEP_SECOND_PCT: rsp_char_in = PercentChar;
         STEP_SECOND_HI:  rsp_char_in = hex_digit(head.byte1[7:4]);
         STEP_SECOND_LO:  rsp_char_in = hex_digit(head.byte1[3:0]);
         default:         rsp_char_in = PercentChar;
      endcase
   end

   always_comb begin
      rsp_last_in  = is_last;
      rsp_valid_in = load ? !status.empty : rsp_valid_ff;
      step_in      = step_ff;
      if (fire) begin
         step_in = is_last ? STEP_FIRST_PCT : step_type'(step_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_FIRST_PCT;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_char_ff <= rsp_char_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_char_ff;
   assign rsp_last_of_run = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_raw_single_step: assert property (@(posedge clock) disable iff (reset)
      (!status.empty && head.kind == KIND_RAW) |-> step_ff == STEP_FIRST_PCT)
      else $error("raw character not emitted in one step");
   a_esc1_short: assert property (@(posedge clock) disable iff (reset)
      (!status.empty && head.kind == KIND_ESC1) |->
      (step_ff == STEP_FIRST_PCT || step_ff == STEP_FIRST_HI ||
       step_ff == STEP_FIRST_LO))
      else $error("single escape ran past three characters");
   a_idle_step_reset: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> step_ff == STEP_FIRST_PCT)
      else $error("sequencer mid-run with no request queued");
`endif

endmodule

### hdl/cp1251_url_percent_encoder_top.sv
// An accepted request goes to a queue slot, then its first character to the output register.
// With rsp_stall low, raw bytes pass at one request per cycle and the single output sequencer
// sends one character a cycle; an escaped byte gives three characters, a Cyrillic byte six.
// A four-entry queue between classifier and sequencer absorbs short bursts.
// Reset is synchronous and active high; it empties the queue and sets escape_reserved to 1.
module cp1251_url_percent_encoder_top
   import cpenc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run
);

   logic             push;
   logic             pop;
   entry_type        push_entry;
   entry_type        head;
   queue_status_type status;

   assign req_stall = status.full;

   cpenc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (req_valid && !req_stall),
      .char_byte   (req_char_byte),
      .push        (push),
      .entry       (push_entry)
   );

   cpenc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   cpenc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .status          (status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

### tb/tb_cp1251_url_percent_encoder_top.sv
`timescale 1ns / 1ps

module tb_cp1251_url_percent_encoder_top;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_of_run;
   } url_char_type;

   localparam logic [10:0] CyrillicBase = 11'h350;
   localparam logic [7:0] CyrillicFirst = 8'hC0;
   localparam logic [7:0] HighFirst = 8'h80;
   localparam logic [7:0] YoUpper = 8'hA8;
   localparam logic [7:0] YoLower = 8'hB8;
   localparam logic [7:0] PercentSign = 8'h25;
   localparam logic [7:0] ReservedSet [15] = '{
      8'h0A, 8'h20, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2B, 8'h2C,
      8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h7E
   };
   localparam int SettleCycles = 12;
   localparam int LongHoldCycles = 150;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_last_of_run;

   logic [7:0]   link_bytes [$];
   url_char_type expected_chars [$];
   logic         escape_mode = 1'b1;
   int           mismatch_count = 0;

   int         burst_left = 8;
   int         gap_left = 0;

   int         hold_left = 0;
   int         stretch_left = 0;
   int         stall_mode = 0;
   logic       stall_next;
   logic       long_hold_armed = 1'b0;
   logic       long_hold_done = 1'b0;

   url_char_type oldest;

   cp1251_url_percent_encoder_top DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_byte   (req_char_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [7:0] nibble_to_hex(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = 8'h30 + {4'd0, nib};
      end else begin
         ch = 8'h61 + {4'd0, nib} - 8'd10;
      end
      return ch;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic predict_url_chars(input logic [7:0] src);
      logic [7:0]  chars [$];
      logic [7:0]  escaped [$];
      logic [10:0] code_point;
      logic        reserved_hit;
      int          i;
      reserved_hit = 1'b0;
      for (i = 0; i < 15; i++) begin
         if (ReservedSet[i] == src) begin
            reserved_hit = 1'b1;
         end
      end
      if (src >= CyrillicFirst) begin
         code_point = CyrillicBase + {3'd0, src};
         escaped.push_back(8'hC0 | {3'd0, code_point[10:6]});
         escaped.push_back(8'h80 | {2'd0, code_point[5:0]});
      end else if (src == YoUpper) begin
         escaped.push_back(8'hD0);
         escaped.push_back(8'h81);
      end else if (src == YoLower) begin
         escaped.push_back(8'hD1);
         escaped.push_back(8'h91);
      end else if (src >= HighFirst) begin
      end else if (escape_mode && reserved_hit) begin
         escaped.push_back(src);
      end else begin
         chars.push_back(src);
      end
      foreach (escaped[k]) begin
         chars.push_back(PercentSign);
         chars.push_back(nibble_to_hex(escaped[k][7:4]));
         chars.push_back(nibble_to_hex(escaped[k][3:0]));
      end
      foreach (chars[k]) begin
         expected_chars.push_back('{out_char: chars[k],
                                    last_of_run: (k == chars.size() - 1)});
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_url_chars(req_char_byte);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || link_bytes.size() == 0) begin
               if (gap_left > 0) begin
                  gap_left--;
               end
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_char_byte <= link_bytes.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (long_hold_armed && !long_hold_done) begin
            hold_left = LongHoldCycles;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            if (stretch_left == 0) begin
               stall_mode = $urandom_range(0, 2);
               stretch_left = $urandom_range(8, 40);
            end
            stretch_left--;
            case (stall_mode)
               0: stall_next = 1'b0;
               1: stall_next = $urandom_range(0, 1);
               default: stall_next = ($urandom_range(0, 3) != 0);
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h", rsp_out_char));
         end else begin
            oldest = expected_chars.pop_front();
            if (rsp_out_char !== oldest.out_char) begin
               report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                         rsp_out_char, oldest.out_char));
            end
            if (rsp_last_of_run !== oldest.last_of_run) begin
               report_mismatch($sformatf("last_of_run %0b, expected %0b on char 0x%02h",
                                         rsp_last_of_run, oldest.last_of_run,
                                         oldest.out_char));
            end
         end
      end
   end

   task automatic write_escape_mode(input logic value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      escape_mode = value;
   endtask

   task automatic wait_until_idle();
      do begin
         @(posedge clock);
      end while (link_bytes.size() != 0 || req_valid || expected_chars.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic run_random_link(input int count);
      logic [7:0] pick;
      int         i;
      for (i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: pick = CyrillicFirst + 8'($urandom_range(0, 63));
            3: pick = $urandom_range(0, 1) ? YoUpper : YoLower;
            4: pick = HighFirst + 8'($urandom_range(0, 63));
            5, 6: pick = ReservedSet[$urandom_range(0, 14)];
            default: pick = 8'($urandom_range(1, 127));
         endcase
         link_bytes.push_back(pick);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_escape_mode(1'b1);
      link_bytes = '{8'h01, 8'h7F, 8'hFF, 8'hC0, 8'h80, 8'hBF, 8'hA8, 8'hB8,
                     8'h0A, 8'h20, 8'h25, 8'h7E, 8'h41, 8'h00, 8'hE0, 8'h30};
      wait_until_idle();

      write_escape_mode(1'b0);
      link_bytes = '{8'h0A, 8'h20, 8'h23, 8'h3F, 8'h40, 8'h7E, 8'hC5, 8'h9F};
      wait_until_idle();

      write_escape_mode(1'b1);
      @(posedge clock);
      long_hold_armed = 1'b1;
      run_random_link(36);
      wait_until_idle();

      write_escape_mode(1'b0);
      run_random_link(36);
      wait_until_idle();

      write_escape_mode(1'b1);
      run_random_link(36);
      wait_until_idle();

      write_escape_mode(1'b0);
      run_random_link(36);
      wait_until_idle();

      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

### files.f
hdl/cpenc_pkg.sv
hdl/cpenc_front.sv
hdl/cpenc_queue.sv
hdl/cpenc_back.sv
hdl/cp1251_url_percent_encoder_top.sv
tb/tb_cp1251_url_percent_encoder_top.sv
